### src/ode_rk_pkg.sv
// Shared types, microcode control word and microprogram table for the RK integrator.
// No dependencies; imported by ode_explicit_runge_kutta_solver.
`default_nettype none

package ode_rk_pkg;

    localparam int UW   = 36;  // width of the divide-by-three operand
    localparam int NDIG = 9;   // radix-16 digits in that operand

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NOSTEP,
        STAT_LIMIT,
        STAT_ZERO
    } t_status;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ARG,   // form stage abscissa and value arguments
        OP_FN,    // f = (x - y) / 2
        OP_MULF,  // product = h * f
        OP_MULC,  // product = constant * operand
        OP_QWR,   // write scaled product to a k register, t or the x offset
        OP_SUM,   // weighted sum of the stages, power-of-two scaling
        OP_DSET,  // set up divide by three
        OP_DITR,  // one radix-16 quotient digit
        OP_UPD,   // advance x and y
        OP_LOOP   // next step or finish
    } t_op;

    typedef enum logic [1:0] {
        A_H,
        A_HALF,
        A_THIRD,
        A_TWO3
    } t_asel;

    typedef enum logic [1:0] {
        B_F,
        B_K1,
        B_K2,
        B_H
    } t_bsel;

    typedef enum logic [2:0] {
        D_K1,
        D_K2,
        D_K3,
        D_K4,
        D_T,
        D_XO
    } t_dst;

    typedef enum logic [1:0] {
        X_ZERO,
        X_H,
        X_XO
    } t_xsel;

    typedef enum logic [1:0] {
        C_ZERO,
        C_POS,
        C_NEG,
        C_TWO
    } t_coef;

    typedef struct packed {
        t_op        op;
        t_asel      asel;
        t_bsel      bsel;
        t_dst       dst;
        t_xsel      xsel;
        t_coef      ct;
        t_coef      c1;
        t_coef      c2;
        t_coef      c3;
        logic [2:0] w1;
        logic [2:0] w2;
        logic [2:0] w3;
        logic [2:0] w4;
        logic [1:0] sh;
    } t_uword;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [35:0] coef_term(input t_coef c,
                                                     input logic signed [35:0] v);
        case (c)
            C_ZERO:  return '0;
            C_POS:   return v;
            C_NEG:   return -v;
            C_TWO:   return v <<< 1;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [35:0] wterm(input logic [2:0] w,
                                                 input logic signed [35:0] v);
        case (w)
            3'd0:    return '0;
            3'd1:    return v;
            3'd2:    return v <<< 1;
            3'd3:    return (v <<< 1) + v;
            3'd4:    return v <<< 2;
            default: return '0;
        endcase
    endfunction

    function automatic t_uword w_op(input t_op op);
        t_uword w;
        w      = '0;
        w.op   = op;
        w.asel = A_H;
        w.bsel = B_F;
        w.dst  = D_K1;
        w.xsel = X_ZERO;
        w.ct   = C_ZERO;
        w.c1   = C_ZERO;
        w.c2   = C_ZERO;
        w.c3   = C_ZERO;
        return w;
    endfunction

    function automatic t_uword w_arg(input t_xsel xs, input t_coef ct, input t_coef c1,
                                     input t_coef c2, input t_coef c3);
        t_uword w;
        w      = w_op(OP_ARG);
        w.xsel = xs;
        w.ct   = ct;
        w.c1   = c1;
        w.c2   = c2;
        w.c3   = c3;
        return w;
    endfunction

    function automatic t_uword w_qwr(input t_dst d);
        t_uword w;
        w     = w_op(OP_QWR);
        w.dst = d;
        return w;
    endfunction

    function automatic t_uword w_mulc(input t_asel a, input t_bsel b);
        t_uword w;
        w      = w_op(OP_MULC);
        w.asel = a;
        w.bsel = b;
        return w;
    endfunction

    function automatic t_uword w_sum(input logic [2:0] w1, input logic [2:0] w2,
                                     input logic [2:0] w3, input logic [2:0] w4,
                                     input logic [1:0] sh);
        t_uword w;
        w    = w_op(OP_SUM);
        w.w1 = w1;
        w.w2 = w2;
        w.w3 = w3;
        w.w4 = w4;
        w.sh = sh;
        return w;
    endfunction

    // Stage evaluation tail: f, h*f, write k.
    function automatic t_uword w_tail(input logic [1:0] ph, input t_dst d);
        case (ph)
            2'd0:    return w_op(OP_FN);
            2'd1:    return w_op(OP_MULF);
            default: return w_qwr(d);
        endcase
    endfunction

    // Microprogram: one word per step, indexed by method and program counter.
    function automatic t_uword ucode(input logic [2:0] mode, input logic [4:0] pc);
        t_uword w;
        w = w_op(OP_NOP);
        if (pc == 5'd0) begin
            w = w_arg(X_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        end else if (pc < 5'd4) begin
            w = w_tail(2'(pc - 5'd1), D_K1);
        end else begin
            case (mode)
                3'd0: begin
                    case (pc)
                        5'd4:    w = w_sum(3'd1, 3'd0, 3'd0, 3'd0, 2'd0);
                        5'd5:    w = w_op(OP_UPD);
                        5'd6:    w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd1: begin
                    case (pc)
                        5'd4:    w = w_arg(X_H, C_ZERO, C_POS, C_ZERO, C_ZERO);
                        5'd5, 5'd6, 5'd7: w = w_tail(2'(pc - 5'd5), D_K2);
                        5'd8:    w = w_sum(3'd1, 3'd1, 3'd0, 3'd0, 2'd1);
                        5'd9:    w = w_op(OP_UPD);
                        5'd10:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd2: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_HALF, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_HALF, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_sum(3'd0, 3'd1, 3'd0, 3'd0, 2'd0);
                        5'd13:   w = w_op(OP_UPD);
                        5'd14:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd3: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_HALF, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_HALF, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_arg(X_H, C_ZERO, C_NEG, C_TWO, C_ZERO);
                        5'd13, 5'd14, 5'd15: w = w_tail(2'(pc - 5'd13), D_K3);
                        5'd16:   w = w_sum(3'd1, 3'd4, 3'd1, 3'd0, 2'd0);
                        5'd17:   w = w_op(OP_DSET);
                        5'd18:   w = w_op(OP_DITR);
                        5'd19:   w = w_op(OP_UPD);
                        5'd20:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd4: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_THIRD, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_THIRD, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_mulc(A_TWO3, B_K2);
                        5'd13:   w = w_qwr(D_T);
                        5'd14:   w = w_mulc(A_TWO3, B_H);
                        5'd15:   w = w_qwr(D_XO);
                        5'd16:   w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd17, 5'd18, 5'd19: w = w_tail(2'(pc - 5'd17), D_K3);
                        5'd20:   w = w_sum(3'd1, 3'd0, 3'd3, 3'd0, 2'd2);
                        5'd21:   w = w_op(OP_UPD);
                        5'd22:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd5: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_TWO3, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_TWO3, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_mulc(A_TWO3, B_K2);
                        5'd13:   w = w_qwr(D_T);
                        5'd14:   w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd15, 5'd16, 5'd17: w = w_tail(2'(pc - 5'd15), D_K3);
                        5'd18:   w = w_sum(3'd2, 3'd3, 3'd3, 3'd0, 2'd3);
                        5'd19:   w = w_op(OP_UPD);
                        5'd20:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                3'd6: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_THIRD, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_THIRD, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_mulc(A_TWO3, B_H);
                        5'd13:   w = w_qwr(D_XO);
                        5'd14:   w = w_arg(X_XO, C_NEG, C_ZERO, C_POS, C_ZERO);
                        5'd15, 5'd16, 5'd17: w = w_tail(2'(pc - 5'd15), D_K3);
                        5'd18:   w = w_arg(X_H, C_ZERO, C_POS, C_NEG, C_POS);
                        5'd19, 5'd20, 5'd21: w = w_tail(2'(pc - 5'd19), D_K4);
                        5'd22:   w = w_sum(3'd1, 3'd3, 3'd3, 3'd1, 2'd3);
                        5'd23:   w = w_op(OP_UPD);
                        5'd24:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
                default: begin
                    case (pc)
                        5'd4:    w = w_mulc(A_HALF, B_K1);
                        5'd5:    w = w_qwr(D_T);
                        5'd6:    w = w_mulc(A_HALF, B_H);
                        5'd7:    w = w_qwr(D_XO);
                        5'd8:    w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd9, 5'd10, 5'd11: w = w_tail(2'(pc - 5'd9), D_K2);
                        5'd12:   w = w_mulc(A_HALF, B_K2);
                        5'd13:   w = w_qwr(D_T);
                        5'd14:   w = w_arg(X_XO, C_POS, C_ZERO, C_ZERO, C_ZERO);
                        5'd15, 5'd16, 5'd17: w = w_tail(2'(pc - 5'd15), D_K3);
                        5'd18:   w = w_arg(X_H, C_ZERO, C_ZERO, C_ZERO, C_POS);
                        5'd19, 5'd20, 5'd21: w = w_tail(2'(pc - 5'd19), D_K4);
                        5'd22:   w = w_sum(3'd1, 3'd2, 3'd2, 3'd1, 2'd0);
                        5'd23:   w = w_op(OP_DSET);
                        5'd24:   w = w_op(OP_DITR);
                        5'd25:   w = w_op(OP_UPD);
                        5'd26:   w = w_op(OP_LOOP);
                        default: w = w_op(OP_NOP);
                    endcase
                end
            endcase
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### src/ode_explicit_runge_kutta_solver.sv
// Explicit Runge-Kutta integrator for y' = (x - y) / 2, microcoded datapath.
// Depends on ode_rk_pkg (types, microprogram table, saturation helpers).
//
//  channel  | signals                                              | dir | handshake
//  ---------+------------------------------------------------------+-----+-----------------------
//  command  | i_mode i_x_start i_y_start i_x_target i_step_size    | in  | start & !busy
//  result   | o_y_result o_status                                  | out | o_done, one cycle
//
// One integration step runs its method's microprogram, from Euler to classical RK4, one
// microcode word per cycle on a single shared 32x32 multiplier, except that the divide
// word repeats once per radix-16 digit of divide-by-three in the two methods whose
// weights sum to six. An item runs its steps, steps <= MAX_STEPS; zero step and no-step
// items go straight to the result. Synchronous active-low reset returns to idle; the result
// strobe cannot be stalled, busy stays high until the result cycle ends.
`default_nettype none

module ode_explicit_runge_kutta_solver
    import ode_rk_pkg::*;
#(
    parameter int MAX_STEPS = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_x_start,
    input  wire logic signed [31:0] i_y_start,
    input  wire logic signed [31:0] i_x_target,
    input  wire logic [30:0]        i_step_size,
    output logic                    o_done,
    output logic signed [31:0]      o_y_result,
    output logic [1:0]              o_status
);

    localparam int    CW    = $clog2(MAX_STEPS + 1);
    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint THRD = (ONE + 1) / 3;
    localparam longint TWO3 = (2 * ONE + 1) / 3;
    localparam logic signed [31:0] K_HALF  = 32'(ONE / 2);
    localparam logic signed [31:0] K_THIRD = 32'(THRD);
    localparam logic signed [31:0] K_TWO3  = 32'(TWO3);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_STEPS);

    t_state  r_state, n_state;
    logic [4:0] r_pc, n_pc;
    t_status r_status;
    t_uword  uw;

    logic [2:0]         r_mode;
    logic [30:0]        r_h;
    logic signed [33:0] r_x, r_xn, r_xt, r_xa, r_t, r_xo;
    logic signed [31:0] r_y, r_f, r_k1, r_k2, r_k3, r_k4;
    logic signed [35:0] r_ya, r_s, r_d;
    logic signed [63:0] r_prod;
    logic [UW-1:0]      r_u, r_q;
    logic [1:0]         r_rem;
    logic [3:0]         r_dig;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;

    logic signed [33:0] in_x, in_xn;
    logic               in_zero, in_nostep, accept;
    logic signed [33:0] h34;
    logic signed [63:0] q;
    logic signed [31:0] mul_a, mul_b;
    logic signed [33:0] xa_nx;
    logic signed [35:0] ya_nx, sum_nx, s2;
    logic signed [31:0] ysat, f_nx;
    logic signed [63:0] fdiff;
    logic [5:0]         cur;
    logic [11:0]        cur43;
    logic [3:0]         qd;
    logic [1:0]         rem_nx;
    logic [UW-1:0]      qn;
    logic               dig_last, loop_end;

    assign uw       = ucode(r_mode, r_pc);
    assign accept   = start && !busy;
    assign in_x     = {{2{i_x_start[31]}}, i_x_start};
    assign in_xn    = in_x + {3'b000, i_step_size};
    assign in_zero  = (i_step_size == '0);
    assign in_nostep = (in_xn > $signed({{2{i_x_target[31]}}, i_x_target}));
    assign h34      = {3'b000, r_h};
    assign q        = r_prod >>> FRAC_BITS;
    assign dig_last = (r_dig == 4'(NDIG - 1));
    assign loop_end = (r_cnt == CNT_MAX) || (r_xn > r_xt);

    // multiplier operands
    always_comb begin
        case (uw.asel)
            A_H:     mul_a = {1'b0, r_h};
            A_HALF:  mul_a = K_HALF;
            A_THIRD: mul_a = K_THIRD;
            A_TWO3:  mul_a = K_TWO3;
            default: mul_a = '0;
        endcase
        if (uw.op == OP_MULF) begin
            mul_a = {1'b0, r_h};
        end
        case (uw.bsel)
            B_F:     mul_b = r_f;
            B_K1:    mul_b = r_k1;
            B_K2:    mul_b = r_k2;
            B_H:     mul_b = {1'b0, r_h};
            default: mul_b = '0;
        endcase
        if (uw.op == OP_MULF) begin
            mul_b = r_f;
        end
    end

    // stage arguments, f, weighted sum
    always_comb begin
        case (uw.xsel)
            X_ZERO:  xa_nx = r_x;
            X_H:     xa_nx = r_x + h34;
            X_XO:    xa_nx = r_x + r_xo;
            default: xa_nx = r_x;
        endcase
        ya_nx = 36'(r_y) + coef_term(uw.ct, 36'(r_t))
              + coef_term(uw.c1, 36'(r_k1)) + coef_term(uw.c2, 36'(r_k2))
              + coef_term(uw.c3, 36'(r_k3));
        ysat  = sat32(64'(r_ya));
        fdiff = 64'(r_xa) - 64'(ysat);
        f_nx  = sat32(fdiff >>> 1);
        sum_nx = wterm(uw.w1, 36'(r_k1)) + wterm(uw.w2, 36'(r_k2))
               + wterm(uw.w3, 36'(r_k3)) + wterm(uw.w4, 36'(r_k4));
        s2     = r_s >>> 1;
    end

    // radix-16 divide by three: digit = floor(cur / 3) via multiply by 43 / 128
    always_comb begin
        cur    = {r_rem, r_u[UW-1 -: 4]};
        cur43  = 12'(cur) * 12'd43;
        qd     = cur43[10:7];
        rem_nx = 2'(cur - 6'(qd) * 6'd3);
        qn     = {r_q[UW-5:0], qd};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (in_zero || in_nostep) ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                if (uw.op == OP_LOOP && loop_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // program counter: holds during the divide digits, jumps back to the top of the program on loop
    always_comb begin
        n_pc = r_pc + 5'd1;
        if (r_state != S_RUN) begin
            n_pc = '0;
        end else if (uw.op == OP_LOOP) begin
            n_pc = '0;
        end else if (uw.op == OP_DITR && !dig_last) begin
            n_pc = r_pc;
        end
    end

    // outputs
    always_comb begin
        busy       = (r_state != S_IDLE);
        o_done     = (r_state == S_FIN);
        o_y_result = r_y;
        o_status   = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_mode <= i_mode;
            r_h    <= i_step_size;
            r_x    <= in_x;
            r_xn   <= in_xn;
            r_xt   <= {{2{i_x_target[31]}}, i_x_target};
            r_y    <= i_y_start;
            r_cnt  <= '0;
            if (in_zero) begin
                r_status <= STAT_ZERO;
            end else if (in_nostep) begin
                r_status <= STAT_NOSTEP;
            end else begin
                r_status <= STAT_OK;
            end
        end else if (r_state == S_RUN) begin
            case (uw.op)
                OP_ARG: begin
                    r_xa <= xa_nx;
                    r_ya <= ya_nx;
                end
                OP_FN: r_f <= f_nx;
                OP_MULF, OP_MULC: r_prod <= mul_a * mul_b;
                OP_QWR: begin
                    case (uw.dst)
                        D_K1:    r_k1 <= sat32(q);
                        D_K2:    r_k2 <= sat32(q);
                        D_K3:    r_k3 <= sat32(q);
                        D_K4:    r_k4 <= sat32(q);
                        D_T:     r_t  <= q[33:0];
                        D_XO:    r_xo <= q[33:0];
                        default: r_t  <= q[33:0];
                    endcase
                end
                OP_SUM: begin
                    r_s <= sum_nx;
                    r_d <= sum_nx >>> uw.sh;
                end
                OP_DSET: begin
                    // floor(s/3) for negative s is -floor((2 - s) / 3)
                    r_neg <= s2[35];
                    r_u   <= s2[35] ? UW'(36'sd2 - s2) : UW'(s2);
                    r_q   <= '0;
                    r_rem <= '0;
                    r_dig <= '0;
                end
                OP_DITR: begin
                    r_u   <= r_u << 4;
                    r_q   <= qn;
                    r_rem <= rem_nx;
                    r_dig <= r_dig + 4'd1;
                    if (dig_last) begin
                        r_d <= r_neg ? -$signed(qn) : $signed(qn);
                    end
                end
                OP_UPD: begin
                    r_y   <= sat32(64'(r_y) + 64'(r_d));
                    r_x   <= r_xn;
                    r_xn  <= r_xn + h34;
                    r_cnt <= r_cnt + CW'(1);
                end
                OP_LOOP: begin
                    if (r_cnt == CNT_MAX && r_xn <= r_xt) begin
                        r_status <= STAT_LIMIT;
                    end
                end
                default: r_f <= r_f;
            endcase
        end
    end

endmodule

`default_nettype wire
